[rtl/vbc_pkg.sv]
// ----------------------------------------------------------------------------
// vbc_pkg: shared types and constants for the block chain checker
// Holds the phase and code types, the result record, the CRC16 byte update
// and the confidence rule used by the checker datapath.
// ----------------------------------------------------------------------------
package vbc_pkg;

    // Largest number of blocks walked before the chain is cut off.
    localparam int MAX_BLOCKS = 4096;
    localparam int CNT_W      = 13;

    // CRC16 CCITT-FALSE polynomial.
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COMPRESSED = 2'd0;
    localparam logic [1:0] CFG_BODY_SIZE  = 2'd1;
    localparam logic [1:0] CFG_CRC_SEED   = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CRC     = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        STOP_EXACT_END    = 3'd0,
        STOP_SHORT_HEADER = 3'd1,
        STOP_ZERO_LENGTH  = 3'd2,
        STOP_OVERRUN      = 3'd3,
        STOP_NO_CRC_ROOM  = 3'd4,
        STOP_BLOCK_LIMIT  = 3'd5
    } stop_t;

    typedef enum logic [1:0] {
        CONF_VERIFIED   = 2'd0,
        CONF_EXACT_END  = 2'd1,
        CONF_CONSISTENT = 2'd2,
        CONF_NO_BLOCKS  = 2'd3
    } conf_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic             block_valid;
        logic [31:0]      block_address;
        logic [31:0]      block_length;
        logic             block_crc_ok;
        logic             chain_done;
        logic [2:0]       stop_reason;
        logic [CNT_W-1:0] blocks_counted;
        logic [31:0]      span_bytes;
        logic [1:0]       confidence;
    } result_t;

    // Bytewise CRC16 update, MSB first, no reflection.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

    // Confidence the walk would report if it stopped with this state.
    function automatic conf_t conf_calc(input logic [CNT_W-1:0] count,
                                        input logic compressed,
                                        input logic checked,
                                        input logic all_ok,
                                        input logic [31:0] consumed,
                                        input logic [31:0] body);
        conf_t conf;
        if (count == '0)
            conf = CONF_NO_BLOCKS;
        else if (!compressed && checked && all_ok)
            conf = CONF_VERIFIED;
        else if (consumed == body)
            conf = CONF_EXACT_END;
        else
            conf = CONF_CONSISTENT;
        return conf;
    endfunction

endpackage

[rtl/vbf_block_chain_checker.sv]
// ----------------------------------------------------------------------------
// vbf_block_chain_checker: block chain walker with CRC16 check
// Parses address/length/payload/CRC blocks from a byte stream and reports
// every finished block and the point where the walk stops.
// ----------------------------------------------------------------------------
// The block takes one chain byte per clock cycle while in_stall is low and
// gives at most one registered result per accepted byte. Each byte
// is handled in a single pass: the CRC16 byte update, the header shifts and
// the length/room compares all sit between the walk state registers and the
// result register. Results leave through an output register backed by one
// skid register, so in_stall rises only when both hold a result that the
// receiver has not taken. The configuration port is always ready; writes
// take effect at the next byte, and crc_seed is loaded at each header end.
// After the walk stops, bytes are accepted and dropped until reset.
module vbf_block_chain_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    // Byte input
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    // Configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    // Result output
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 block_valid,
    output logic [31:0]          block_address,
    output logic [31:0]          block_length,
    output logic                 block_crc_ok,
    output logic                 chain_done,
    output logic [2:0]           stop_reason,
    output logic [vbc_pkg::CNT_W-1:0] blocks_counted,
    output logic [31:0]          span_bytes,
    output logic [1:0]           confidence
);
    import vbc_pkg::*;

    // Configuration registers.
    logic        compressed_reg;
    logic [31:0] body_size_reg;
    logic [15:0] crc_seed_reg;

    // Walk state.
    phase_t           phase_reg, phase_next;
    logic [2:0]       idx_reg, idx_next;
    logic [31:0]      addr_reg, addr_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      left_reg, left_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic [31:0]      consumed_reg, consumed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             all_ok_reg, all_ok_next;
    logic             checked_reg, checked_next;

    // Output buffer.
    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;

    logic        in_fire, out_fire, res_fire;
    logic [32:0] room;
    logic        short_start, limit_start;
    logic        hdr_start_stop, hdr_end, hdr_end_stop, crc_end;
    logic [31:0] len_shifted, avail;
    logic        len_zero, len_over, crc_over;
    logic [15:0] stored_crc;
    logic        crc_match, blk_ok;
    logic [31:0] consumed_blk;
    logic [CNT_W-1:0] count_blk;
    logic [32:0] room_blk;
    logic        blk_exact, blk_limit, blk_short, blk_stop;
    stop_t       hdr_reason, blk_reason, start_reason;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compressed_reg <= 1'b0;
            body_size_reg  <= '0;
            crc_seed_reg   <= 16'hFFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COMPRESSED: compressed_reg <= cfg_data[0];
                CFG_BODY_SIZE:  body_size_reg  <= cfg_data;
                CFG_CRC_SEED:   crc_seed_reg   <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // Room left in the body; the top bit marks an overdrawn body.
    assign room        = {1'b0, body_size_reg} - {1'b0, consumed_reg};
    assign short_start = room[32] || (room[31:3] == '0);
    assign limit_start = ({1'b0, count_reg} >= (CNT_W+1)'(MAX_BLOCKS));
    assign start_reason = limit_start ? STOP_BLOCK_LIMIT : STOP_SHORT_HEADER;
    assign hdr_start_stop = (phase_reg == PH_HEADER) && (idx_reg == 3'd0) &&
                            (limit_start || short_start);

    // Header end: length checks against the room after the header.
    assign hdr_end     = (phase_reg == PH_HEADER) && (idx_reg == 3'd7);
    assign len_shifted = {len_reg[23:0], data_byte};
    assign avail       = room[31:0] - 32'd8;
    assign len_zero    = (len_shifted == '0);
    assign len_over    = !short_start && (len_shifted > avail);
    assign crc_over    = !short_start &&
                         (({1'b0, len_shifted} + 33'd2) > {1'b0, avail});
    assign hdr_end_stop = hdr_end && (len_zero || len_over || crc_over);
    always_comb
    begin
        priority if (len_zero)
            hdr_reason = STOP_ZERO_LENGTH;
        else if (len_over)
            hdr_reason = STOP_OVERRUN;
        else
            hdr_reason = STOP_NO_CRC_ROOM;
    end

    // Block end: CRC compare and the stop checks on the updated totals.
    assign crc_end      = (phase_reg == PH_CRC) && idx_reg[0];
    assign stored_crc   = {crc_hi_reg, data_byte};
    assign crc_match    = (crc_reg == stored_crc);
    assign blk_ok       = compressed_reg || crc_match;
    assign consumed_blk = consumed_reg + 32'd10 + len_reg;
    assign count_blk    = count_reg + 1'b1;
    assign room_blk     = {1'b0, body_size_reg} - {1'b0, consumed_blk};
    assign blk_exact    = (consumed_blk == body_size_reg);
    assign blk_limit    = ({1'b0, count_blk} >= (CNT_W+1)'(MAX_BLOCKS));
    assign blk_short    = room_blk[32] || (room_blk[31:3] == '0);
    assign blk_stop     = blk_exact || blk_limit || blk_short;
    always_comb
    begin
        priority if (blk_exact)
            blk_reason = STOP_EXACT_END;
        else if (blk_limit)
            blk_reason = STOP_BLOCK_LIMIT;
        else
            blk_reason = STOP_SHORT_HEADER;
    end

    assign res_fire = in_fire && (hdr_start_stop || hdr_end_stop || crc_end);

    // Next state of the walk.
    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        left_next     = left_reg;
        crc_next      = crc_reg;
        crc_hi_next   = crc_hi_reg;
        consumed_next = consumed_reg;
        count_next    = count_reg;
        all_ok_next   = all_ok_reg;
        checked_next  = checked_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_start_stop)
                        phase_next = PH_DONE;
                    else
                    begin
                        if (!idx_reg[2])
                            addr_next = {addr_reg[23:0], data_byte};
                        else
                            len_next = len_shifted;
                        idx_next = idx_reg + 1'b1;
                        if (hdr_end_stop)
                            phase_next = PH_DONE;
                        else if (hdr_end)
                        begin
                            left_next  = len_shifted;
                            crc_next   = crc_seed_reg;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (!compressed_reg)
                        crc_next = crc_byte(crc_reg, data_byte);
                    left_next = left_reg - 1'b1;
                    if (left_reg == 32'd1)
                    begin
                        phase_next = PH_CRC;
                        idx_next   = '0;
                    end
                end
                PH_CRC:
                begin
                    crc_hi_next = data_byte;
                    if (!crc_end)
                        idx_next = 3'd1;
                    else
                    begin
                        idx_next      = '0;
                        consumed_next = consumed_blk;
                        count_next    = count_blk;
                        if (!compressed_reg)
                        begin
                            checked_next = 1'b1;
                            all_ok_next  = all_ok_reg && crc_match;
                        end
                        phase_next = blk_stop ? PH_DONE : PH_HEADER;
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end
    end

    // Result item for the accepted byte.
    always_comb
    begin
        res = '0;
        if (crc_end)
        begin
            res.block_valid    = 1'b1;
            res.block_address  = addr_reg;
            res.block_length   = len_reg;
            res.block_crc_ok   = blk_ok;
            res.chain_done     = blk_stop;
            res.stop_reason    = blk_stop ? blk_reason : STOP_EXACT_END;
            res.blocks_counted = count_blk;
            res.span_bytes     = consumed_blk;
            res.confidence     = conf_calc(count_blk, compressed_reg,
                                           checked_reg || !compressed_reg,
                                           all_ok_reg && blk_ok,
                                           consumed_blk, body_size_reg);
        end
        else
        begin
            res.chain_done     = 1'b1;
            res.stop_reason    = hdr_start_stop ? start_reason : hdr_reason;
            res.blocks_counted = count_reg;
            res.span_bytes     = consumed_reg;
            res.confidence     = conf_calc(count_reg, compressed_reg, checked_reg,
                                           all_ok_reg, consumed_reg, body_size_reg);
        end
    end

    // Walk state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            idx_reg      <= '0;
            addr_reg     <= '0;
            len_reg      <= '0;
            left_reg     <= '0;
            crc_reg      <= 16'hFFFF;
            crc_hi_reg   <= '0;
            consumed_reg <= '0;
            count_reg    <= '0;
            all_ok_reg   <= 1'b1;
            checked_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            addr_reg     <= addr_next;
            len_reg      <= len_next;
            left_reg     <= left_next;
            crc_reg      <= crc_next;
            crc_hi_reg   <= crc_hi_next;
            consumed_reg <= consumed_next;
            count_reg    <= count_next;
            all_ok_reg   <= all_ok_next;
            checked_reg  <= checked_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
            out_valid_reg <= res_fire;
        else if (res_fire)
            skid_valid_reg <= 1'b1;
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (res_fire)
                out_reg <= res;
        end
        else if (res_fire)
            skid_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign block_valid    = out_reg.block_valid;
    assign block_address  = out_reg.block_address;
    assign block_length   = out_reg.block_length;
    assign block_crc_ok   = out_reg.block_crc_ok;
    assign chain_done     = out_reg.chain_done;
    assign stop_reason    = out_reg.stop_reason;
    assign blocks_counted = out_reg.blocks_counted;
    assign span_bytes     = out_reg.span_bytes;
    assign confidence     = out_reg.confidence;

endmodule

[rtl/vbc_chain_checker.sv]
// ----------------------------------------------------------------------------
// vbc_chain_checker: port-level checks for the block chain checker
// Watches the result channel and the consistency of the reported fields.
// ----------------------------------------------------------------------------
module vbc_chain_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 block_valid,
    input logic [31:0]          block_address,
    input logic [31:0]          block_length,
    input logic                 block_crc_ok,
    input logic                 chain_done,
    input logic [2:0]           stop_reason,
    input logic [vbc_pkg::CNT_W-1:0] blocks_counted,
    input logic [1:0]           confidence
);
    import vbc_pkg::*;

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(block_address) &&
        $stable(blocks_counted) && $stable(chain_done))
        else $error("result changed while stalled");

    // A result without a block is always a stop.
    a_stop_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !block_valid |-> chain_done && block_address == '0 &&
        block_length == '0 && !block_crc_ok)
        else $error("non-block result is not a clean stop");

    // A running walk reports no stop reason.
    a_no_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chain_done |-> stop_reason == STOP_EXACT_END)
        else $error("stop reason set on a running walk");

    // A reported block is counted and leaves the no-blocks confidence.
    a_block_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_valid |-> blocks_counted != '0 &&
        confidence != CONF_NO_BLOCKS)
        else $error("block result with no block counted");

    // Length stops (zero length, overrun, no CRC room) only happen at a header end, never with a block.
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (stop_reason == STOP_ZERO_LENGTH ||
        stop_reason == STOP_OVERRUN || stop_reason == STOP_NO_CRC_ROOM)
        |-> !block_valid)
        else $error("length stop reported with a block");

endmodule

bind vbf_block_chain_checker vbc_chain_checker u_vbc_chain_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .block_valid    (block_valid),
    .block_address  (block_address),
    .block_length   (block_length),
    .block_crc_ok   (block_crc_ok),
    .chain_done     (chain_done),
    .stop_reason    (stop_reason),
    .blocks_counted (blocks_counted),
    .confidence     (confidence)
);
